// ===== hw/rtl/php_pkg.sv =====
// Shared types and constants for the picture header parser.
package php_pkg;

  localparam int HDR_BITS = 17;
  localparam int ROWS_W   = 8;
  localparam int DIV_W    = 4;
  localparam int STEP_W   = 3;

  localparam logic [7:0] CFG_MB_ROWS     = 8'd0;
  localparam logic [7:0] CFG_FLIP_ROUND  = 8'd1;

  localparam logic [1:0] PTYPE_INTRA     = 2'd0;
  localparam logic [1:0] PTYPE_PRED      = 2'd1;

  localparam logic [4:0] SLICE_BASE      = 5'h16;
  localparam logic [2:0] CHROMA_BASE     = 3'd3;
  localparam logic [4:0] REJECT_BITS     = 5'd7;
  localparam logic [STEP_W-1:0] LAST_STEP = 3'd7;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } php_cmd_t;

  typedef struct packed {
    logic out_free;
  } php_status_t;

endpackage

// ===== hw/rtl/picture_header_parser.sv =====
// Picture header parser: reads one picture header per transfer and reports table selects.
// For each header, the window is captured at the transfer in, then the one-bit-per-cycle
// slice height divider runs, and a commit updates the picture state and loads the result
// register. The next header is taken in the cycle after commit, so no new header is taken
// while the previous one is still being divided. A new header
// is taken once the previous one has committed, even while its result still waits
// downstream; commit waits only if that result has not been taken.
// The first header bit sits at bit WINDOW_BITS-1; at most 17 bits are read. Configuration
// writes are taken whenever reset is low; write only while no header is in flight.
module picture_header_parser #(
  parameter int WINDOW_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [WINDOW_BITS-1:0] header_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   header_ok,
  output logic [1:0]             picture_type,
  output logic [4:0]             quantizer,
  output logic [7:0]             slice_rows,
  output logic [1:0]             rl_select_luma,
  output logic [2:0]             rl_select_chroma,
  output logic                   dc_table_select,
  output logic                   mv_table_select,
  output logic                   coded_bit_flag,
  output logic                   rounding,
  output logic [4:0]             bits_used,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [7:0]             cfg_index,
  input  logic [7:0]             cfg_data
);

  php_pkg::php_cmd_t    cmd;
  php_pkg::php_status_t status;

  assign cfg_ready = !rst;

  php_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  php_datapath #(
    .WINDOW_BITS (WINDOW_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .header_word      (header_word),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .header_ok        (header_ok),
    .picture_type     (picture_type),
    .quantizer        (quantizer),
    .slice_rows       (slice_rows),
    .rl_select_luma   (rl_select_luma),
    .rl_select_chroma (rl_select_chroma),
    .dc_table_select  (dc_table_select),
    .mv_table_select  (mv_table_select),
    .coded_bit_flag   (coded_bit_flag),
    .rounding         (rounding),
    .bits_used        (bits_used)
  );

endmodule

// ===== hw/rtl/php_ctrl.sv =====
// Controller state machine: accept, divide, commit.
module php_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  php_pkg::php_status_t status,
  output php_pkg::php_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                  state;
  logic [1:0]                  state_next;
  logic [php_pkg::STEP_W-1:0]  cnt;
  logic [php_pkg::STEP_W-1:0]  cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == php_pkg::LAST_STEP) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// ===== hw/rtl/php_datapath.sv =====
// Datapath: header decode, bit-serial slice divider, picture state and result register.
module php_datapath #(
  parameter int WINDOW_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [WINDOW_BITS-1:0] header_word,
  input  logic                   cfg_valid,
  input  logic [7:0]             cfg_index,
  input  logic [7:0]             cfg_data,
  input  php_pkg::php_cmd_t      cmd,
  output php_pkg::php_status_t   status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   header_ok,
  output logic [1:0]             picture_type,
  output logic [4:0]             quantizer,
  output logic [7:0]             slice_rows,
  output logic [1:0]             rl_select_luma,
  output logic [2:0]             rl_select_chroma,
  output logic                   dc_table_select,
  output logic                   mv_table_select,
  output logic                   coded_bit_flag,
  output logic                   rounding,
  output logic [4:0]             bits_used
);

  logic [php_pkg::ROWS_W-1:0]   mb_rows;
  logic                         flip_rounding_enable;

  logic [php_pkg::HDR_BITS-1:0] hdr;
  logic [php_pkg::HDR_BITS-1:0] win;
  logic [4:0]                   code;
  logic [php_pkg::DIV_W-1:0]    divisor;
  logic [php_pkg::DIV_W-1:0]    rem;
  logic [php_pkg::ROWS_W-1:0]   quo;
  logic [php_pkg::DIV_W:0]      rem_sh;
  logic                         ge;

  logic                         rounding_bit;
  logic [7:0]                   slice_rows_reg;
  logic                         mv_select_reg;
  logic                         coded_bit_reg;
  logic [1:0]                   rl_luma_reg;
  logic [2:0]                   rl_chroma_reg;
  logic                         dc_select_reg;

  logic                         ok_reg;
  logic [1:0]                   ptype_reg;
  logic [4:0]                   quant_reg;
  logic [4:0]                   bits_reg;

  logic [1:0]                   ptype;
  logic [4:0]                   p;
  logic [4:0]                   q;
  logic [1:0]                   csel;
  logic [1:0]                   lsel;
  logic                         dc_bit;
  logic                         mv_bit;
  logic                         coded_bit;
  logic [4:0]                   bits_next;

  assign win  = header_word[WINDOW_BITS-1 -: php_pkg::HDR_BITS];
  assign code = win[9:5];

  always_ff @(posedge clk) begin
    if (rst) begin
      mb_rows              <= 8'd1;
      flip_rounding_enable <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == php_pkg::CFG_MB_ROWS) begin
        mb_rows <= cfg_data;
      end else if (cfg_index == php_pkg::CFG_FLIP_ROUND) begin
        flip_rounding_enable <= cfg_data[0];
      end
    end
  end

  assign rem_sh = {rem, quo[php_pkg::ROWS_W-1]};
  assign ge     = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hdr <= win;
      rem <= '0;
      quo <= mb_rows;
      if (code > php_pkg::SLICE_BASE + 5'd1) begin
        divisor <= 4'(code - php_pkg::SLICE_BASE);
      end else begin
        divisor <= 4'd1;
      end
    end else if (cmd.step) begin
      rem <= ge ? 4'(rem_sh - {1'b0, divisor}) : rem_sh[php_pkg::DIV_W-1:0];
      quo <= {quo[php_pkg::ROWS_W-2:0], ge};
    end
  end

  // Bit at header position n is hdr[16 - n].
  always_comb begin
    ptype     = hdr[16:15];
    p         = 5'd0;
    q         = 5'd0;
    csel      = 2'd0;
    lsel      = 2'd0;
    dc_bit    = 1'b0;
    mv_bit    = 1'b0;
    coded_bit = hdr[9];
    bits_next = php_pkg::REJECT_BITS;
    case (ptype)
      php_pkg::PTYPE_INTRA: begin
        if (hdr[4]) begin
          csel = {1'b0, hdr[3]} + 2'd1;
          p    = 5'd14;
        end else begin
          p    = 5'd13;
        end
        if (hdr[5'd16 - p]) begin
          lsel = {1'b0, hdr[5'd15 - p]} + 2'd1;
          q    = p + 5'd2;
        end else begin
          q    = p + 5'd1;
        end
        dc_bit    = hdr[5'd16 - q];
        bits_next = q + 5'd1;
      end
      php_pkg::PTYPE_PRED: begin
        if (hdr[8]) begin
          lsel = {1'b0, hdr[7]} + 2'd1;
          p    = 5'd10;
        end else begin
          p    = 5'd9;
        end
        dc_bit    = hdr[5'd16 - p];
        mv_bit    = hdr[5'd15 - p];
        bits_next = p + 5'd2;
      end
      default: begin
        bits_next = php_pkg::REJECT_BITS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rounding_bit   <= 1'b0;
      slice_rows_reg <= 8'd0;
      mv_select_reg  <= 1'b0;
      coded_bit_reg  <= 1'b0;
      rl_luma_reg    <= 2'd0;
      rl_chroma_reg  <= php_pkg::CHROMA_BASE;
      dc_select_reg  <= 1'b0;
    end else if (cmd.commit) begin
      if (ptype == php_pkg::PTYPE_INTRA) begin
        slice_rows_reg <= quo;
        rl_chroma_reg  <= php_pkg::CHROMA_BASE + {1'b0, csel};
        rl_luma_reg    <= lsel;
        dc_select_reg  <= dc_bit;
        rounding_bit   <= 1'b0;
      end else if (ptype == php_pkg::PTYPE_PRED) begin
        coded_bit_reg  <= coded_bit;
        rl_luma_reg    <= lsel;
        rl_chroma_reg  <= php_pkg::CHROMA_BASE + {1'b0, lsel};
        dc_select_reg  <= dc_bit;
        mv_select_reg  <= mv_bit;
        rounding_bit   <= flip_rounding_enable & ~rounding_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ok_reg    <= (ptype == php_pkg::PTYPE_INTRA) || (ptype == php_pkg::PTYPE_PRED);
      ptype_reg <= ptype;
      quant_reg <= hdr[14:10];
      bits_reg  <= bits_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_free = !out_valid || out_ready;

  assign header_ok        = ok_reg;
  assign picture_type     = ptype_reg;
  assign quantizer        = quant_reg;
  assign bits_used        = bits_reg;
  assign slice_rows       = slice_rows_reg;
  assign rl_select_luma   = rl_luma_reg;
  assign rl_select_chroma = rl_chroma_reg;
  assign dc_table_select  = dc_select_reg;
  assign mv_table_select  = mv_select_reg;
  assign coded_bit_flag   = coded_bit_reg;
  assign rounding         = rounding_bit;

endmodule
